// ----- src/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants for the LRU block buffer cache
// Slot entry layout, request and response payloads, status and kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

   localparam int NUM_SLOTS  = 32;
   localparam int BLOCK_BITS = 20;
   localparam int REF_BITS   = 8;

   localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam int BLOCK_NUMBER_W = 20;
   localparam int SLOT_W         = 5;
   localparam int STATUS_W       = 2;

   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_BUFFER  = 2'd1,
      STATUS_UNHELD     = 2'd2,
      STATUS_COUNT_FULL = 2'd3
   } status_type;

   typedef struct packed {
      logic                      kind;
      logic [BLOCK_NUMBER_W-1:0] block_number;
      logic [SLOT_W-1:0]         slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      logic              hit;
      logic              needs_fill;
      status_type        status;
   } rsp_type;

   // one recency position: which slot sits there and that slot's state
   typedef struct packed {
      logic [SLOT_BITS-1:0]  slot;
      logic [BLOCK_BITS-1:0] tag;
      logic [REF_BITS-1:0]   refs;
      logic                  valid;
   } entry_type;

   function automatic entry_type reset_entry(input int pos);
      entry_type e;
      e.slot  = SLOT_BITS'(NUM_SLOTS - 1 - pos);
      e.tag   = '0;
      e.refs  = '0;
      e.valid = 1'b0;
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- src/lbc_cell.sv -----
// ----------------------------------------------------------------------------
// lbc_cell: one recency position of the slot chain
// Holds one entry and takes its neighbor's entry whenever the chain shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_cell
   import lbc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      shift_en,
   input  wire entry_type init_entry,
   input  wire entry_type next_entry,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift_en ? next_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= init_entry;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- src/lbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbc_ctrl: sequencer for the slot chain
// Scan pass looks at each entry as it rotates past the head; apply pass
// rewrites the chosen entry and, on a final release, moves it to the front.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ctrl
   import lbc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire req_type   req_data,
   input  wire entry_type head,
   output logic           busy,
   output logic           shift_en,
   output entry_type      tail,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_APPLY  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_BITS-1:0]    pos_ff, pos_in;
   logic                    kind_ff, kind_in;
   logic [BLOCK_BITS-1:0]   tag_ff, tag_in;
   logic [SLOT_W-1:0]       rslot_ff, rslot_in;
   logic                    found_ff, found_in;
   entry_type               tgt_ff, tgt_in;
   logic                    free_ff, free_in;
   logic [SLOT_BITS-1:0]    free_slot_ff, free_slot_in;
   logic                    mod_en_ff, mod_en_in;
   logic                    move_ff, move_in;
   entry_type               mod_ff, mod_in;
   entry_type               carry_ff, carry_in;
   logic                    delay_ff, delay_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic      last_pos;
   logic      is_target;
   rsp_type   dec_rsp;
   logic      dec_mod_en;
   logic      dec_move;
   entry_type dec_entry;

   assign last_pos  = (pos_ff == SLOT_BITS'(NUM_SLOTS - 1));
   assign is_target = mod_en_ff && (head.slot == mod_ff.slot);

   // outcome of the scan pass
   always_comb begin
      dec_rsp            = '0;
      dec_rsp.status     = STATUS_OK;
      dec_mod_en         = 1'b0;
      dec_move           = 1'b0;
      dec_entry          = tgt_ff;
      if (kind_ff == KIND_ACQUIRE) begin
         if (found_ff) begin
            dec_rsp.slot_out = SLOT_W'(tgt_ff.slot);
            dec_rsp.hit      = 1'b1;
            if (tgt_ff.refs == REF_MAX) begin
               dec_rsp.status = STATUS_COUNT_FULL;
            end else begin
               dec_mod_en         = 1'b1;
               dec_entry.refs     = tgt_ff.refs + REF_BITS'(1);
               dec_entry.valid    = 1'b1;
               dec_rsp.needs_fill = !tgt_ff.valid;
            end
         end else if (free_ff) begin
            dec_rsp.slot_out   = SLOT_W'(free_slot_ff);
            dec_rsp.needs_fill = 1'b1;
            dec_mod_en         = 1'b1;
            dec_entry.slot     = free_slot_ff;
            dec_entry.tag      = tag_ff;
            dec_entry.refs     = REF_BITS'(1);
            dec_entry.valid    = 1'b1;
         end else begin
            dec_rsp.status = STATUS_NO_BUFFER;
         end
      end else begin
         dec_rsp.slot_out = rslot_ff;
         if (!found_ff || (tgt_ff.refs == '0)) begin
            dec_rsp.status = STATUS_UNHELD;
         end else begin
            dec_mod_en     = 1'b1;
            dec_entry.refs = tgt_ff.refs - REF_BITS'(1);
            dec_move       = (tgt_ff.refs == REF_BITS'(1));
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      tag_in       = tag_ff;
      rslot_in     = rslot_ff;
      found_in     = found_ff;
      tgt_in       = tgt_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      mod_en_in    = mod_en_ff;
      move_in      = move_ff;
      mod_in       = mod_ff;
      carry_in     = carry_ff;
      delay_in     = delay_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      shift_en     = 1'b0;
      tail         = head;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_data.kind;
               tag_in   = BLOCK_BITS'(req_data.block_number);
               rslot_in = req_data.slot;
               found_in = 1'b0;
               free_in  = 1'b0;
               pos_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            shift_en = 1'b1;
            tail     = head;
            if (kind_ff == KIND_ACQUIRE) begin
               if (!found_ff && (head.tag == tag_ff)) begin
                  found_in = 1'b1;
                  tgt_in   = head;
               end
               if (head.refs == '0) begin
                  free_in      = 1'b1;
                  free_slot_in = head.slot;
               end
            end else if (32'(head.slot) == 32'(rslot_ff)) begin
               found_in = 1'b1;
               tgt_in   = head;
            end
            if (last_pos) begin
               pos_in   = '0;
               state_in = ST_DECIDE;
            end else begin
               pos_in = pos_ff + SLOT_BITS'(1);
            end
         end
         ST_DECIDE: begin
            rsp_in    = dec_rsp;
            mod_en_in = dec_mod_en;
            move_in   = dec_move;
            mod_in    = dec_entry;
            delay_in  = 1'b0;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            shift_en = 1'b1;
            if (!move_ff) begin
               tail = is_target ? mod_ff : head;
            end else if (pos_ff == '0) begin
               tail = mod_ff;
               if (is_target) begin
                  delay_in = 1'b0;
               end else begin
                  carry_in = head;
                  delay_in = 1'b1;
               end
            end else if (delay_ff) begin
               tail = carry_ff;
               if (is_target) begin
                  delay_in = 1'b0;
               end else begin
                  carry_in = head;
               end
            end else begin
               tail = head;
            end
            if (last_pos) begin
               pos_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               pos_in = pos_ff + SLOT_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         mod_en_ff    <= 1'b0;
         move_ff      <= 1'b0;
         delay_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         mod_en_ff    <= mod_en_in;
         move_ff      <= move_in;
         delay_ff     <= delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      tag_ff       <= tag_in;
      rslot_ff     <= rslot_in;
      tgt_ff       <= tgt_in;
      free_slot_ff <= free_slot_in;
      mod_ff       <= mod_in;
      carry_ff     <= carry_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/lru_block_buffer_cache.sv -----
// ----------------------------------------------------------------------------
// lru_block_buffer_cache: LRU buffer cache with reference counts
// Slot tags, counts and valid marks kept in recency order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_data and raise start; the request transfers at a
//   rising edge where start is high and busy is low. kind selects acquire
//   (look up block_number) or release (give back slot).
//   Response: rsp_valid is high for exactly one cycle with rsp_data
//   (slot_out, hit, needs_fill, status). The receiver cannot stall; the
//   response must be taken in that cycle.
//   Sequence: the chain rotates once past its head to scan, the controller
//   decides on the outcome, and the chain rotates once more to apply the
//   update. rsp_valid rises when the apply pass ends and busy drops in that
//   same cycle, so the next request can transfer at the edge that takes
//   the response; no new request is taken while one is in progress.
//   The length of the cell chain sets how long each pass lasts.
//   Reset: synchronous; the order becomes highest slot most recent down to
//   slot 0, all tags, counts and valid marks zero, and the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_block_buffer_cache
   import lbc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   entry_type chain [NUM_SLOTS];
   entry_type tail;
   logic      shift_en;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      entry_type next_entry;
      if (i == NUM_SLOTS - 1) begin : g_last
         assign next_entry = tail;
      end else begin : g_mid
         assign next_entry = chain[i+1];
      end
      lbc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .init_entry (reset_entry(i)),
         .next_entry (next_entry),
         .entry      (chain[i])
      );
   end

   lbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .head      (chain[0]),
      .busy      (busy),
      .shift_en  (shift_en),
      .tail      (tail),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/lbc_checker.sv -----
// ----------------------------------------------------------------------------
// lbc_checker: port-level checks for the LRU block buffer cache
// Watches request and response transfers on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_checker
   import lbc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request transfer did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("response while busy");

   a_no_buffer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_NO_BUFFER)) |->
         ((rsp_data.slot_out == '0) && !rsp_data.hit && !rsp_data.needs_fill))
      else $error("no-buffer response carries slot data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (.*);

`default_nettype wire

// ----- sim/tb_lru_block_buffer_cache.sv -----
// ----------------------------------------------------------------------------
// tb_lru_block_buffer_cache: self-checking bench for the LRU block buffer cache
// A clocked driver feeds acquire and release commands from a queue, and a
// clocked monitor checks each reply against a cycle-free model of the cache.
// The stimulus runs through several phases: a few directed commands, then a
// full-cache phase, then a count-saturation phase, then random episodes.
// ----------------------------------------------------------------------------

module tb_lru_block_buffer_cache;
   import lbc_pkg::*;

   localparam int BUSY_CYCLES    = 2 * NUM_SLOTS + 2;
   localparam int WATCHDOG_LIMIT = 16 * BUSY_CYCLES;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int CALM_TAIL      = 150;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // model state; position 0 of recent_slot is most recent
   logic [SLOT_W-1:0]     recent_slot [NUM_SLOTS];
   logic [BLOCK_BITS-1:0] blk_tag     [NUM_SLOTS];
   logic [REF_BITS-1:0]   hold_cnt    [NUM_SLOTS];
   logic                  data_ok     [NUM_SLOTS];

   req_type cmd_queue[$];
   rsp_type pending_replies[$];

   int n_sent     = 0;
   int n_accepted = 0;
   int n_checked  = 0;
   int n_errors   = 0;
   int idle_pct   = 0;
   int idle_left  = 0;
   int quiet      = 0;
   int n_acquire  = 0;
   int n_release  = 0;
   int n_hits     = 0;
   int n_fills    = 0;
   int status_seen [4] = '{default: 0};

   lru_block_buffer_cache DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   task automatic predict_cache_reply(input req_type r, output rsp_type o);
      int                pos;
      int                mv;
      bit                found;
      logic [SLOT_W-1:0] s;
      o     = '0;
      found = 1'b0;
      mv    = 0;
      if (r.kind == KIND_ACQUIRE) begin
         for (pos = 0; pos < NUM_SLOTS && !found; pos++) begin
            s = recent_slot[pos];
            if (blk_tag[s] == r.block_number) begin
               found      = 1'b1;
               o.slot_out = s;
               o.hit      = 1'b1;
               if (hold_cnt[s] == REF_MAX) begin
                  o.status = STATUS_COUNT_FULL;
               end else begin
                  hold_cnt[s]++;
                  if (!data_ok[s]) begin
                     o.needs_fill = 1'b1;
                     data_ok[s]   = 1'b1;
                  end
               end
            end
         end
         // miss: least recent free slot gets retagged
         for (pos = NUM_SLOTS - 1; pos >= 0 && !found; pos--) begin
            s = recent_slot[pos];
            if (hold_cnt[s] == 0) begin
               found        = 1'b1;
               o.slot_out   = s;
               o.needs_fill = 1'b1;
               blk_tag[s]   = r.block_number;
               hold_cnt[s]  = 1;
               data_ok[s]   = 1'b1;
            end
         end
         if (!found)
            o.status = STATUS_NO_BUFFER;
      end else begin
         o.slot_out = r.slot;
         if (hold_cnt[r.slot] == 0) begin
            o.status = STATUS_UNHELD;
         end else begin
            hold_cnt[r.slot]--;
            if (hold_cnt[r.slot] == 0) begin
               for (pos = 0; pos < NUM_SLOTS; pos++)
                  if (recent_slot[pos] == r.slot)
                     mv = pos;
               for (pos = mv; pos > 0; pos--)
                  recent_slot[pos] = recent_slot[pos - 1];
               recent_slot[0] = r.slot;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v, got_v);
      if (got_v !== want_v) begin
         if (n_errors < 10)
            $display("tb: %s mismatch on reply %0d: expected %0d, got %0d",
                     name, n_checked, want_v, got_v);
         n_errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin : drive
      rsp_type want;
      if (reset) begin
         for (int p = 0; p < NUM_SLOTS; p++) begin
            recent_slot[p] = SLOT_W'(NUM_SLOTS - 1 - p);
            blk_tag[p]     = '0;
            hold_cnt[p]    = '0;
            data_ok[p]     = 1'b0;
         end
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            predict_cache_reply(req_data, want);
            pending_replies.push_back(want);
            n_accepted <= n_accepted + 1;
            if (req_data.kind == KIND_ACQUIRE)
               n_acquire++;
            else
               n_release++;
            n_hits  += int'(want.hit);
            n_fills += int'(want.needs_fill);
            status_seen[want.status]++;
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               start     <= 1'b0;
               req_data  <= $bits(req_type)'($urandom);
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
               idle_left <= $urandom_range(15);
               start     <= 1'b0;
               req_data  <= $bits(req_type)'($urandom);
            end else if (cmd_queue.size() > 0) begin
               start    <= 1'b1;
               req_data <= cmd_queue.pop_front();
            end else begin
               start    <= 1'b0;
               req_data <= $bits(req_type)'($urandom);
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         quiet <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               if (n_errors < 10)
                  $display("tb: reply with nothing outstanding: slot %0d status %0d",
                           rsp_data.slot_out, rsp_data.status);
               n_errors++;
            end else begin
               want = pending_replies.pop_front();
               check_field("slot_out", 32'(want.slot_out), 32'(rsp_data.slot_out));
               check_field("hit", 32'(want.hit), 32'(rsp_data.hit));
               check_field("needs_fill", 32'(want.needs_fill),
                           32'(rsp_data.needs_fill));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               n_checked++;
            end
         end
         if (rsp_valid || (start && !busy)) begin
            quiet <= 0;
         end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired, %0d replies outstanding",
                     pending_replies.size());
            $display("tb: failure");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   task automatic send(input req_type r);
      cmd_queue.push_back(r);
      n_sent++;
      wait (n_accepted == n_sent);
   endtask

   task automatic acquire(input logic [BLOCK_BITS-1:0] blk);
      req_type r;
      r.kind         = KIND_ACQUIRE;
      r.block_number = blk;
      r.slot         = SLOT_W'($urandom);
      send(r);
   endtask

   task automatic give_back(input logic [SLOT_W-1:0] s);
      req_type r;
      r.kind         = KIND_RELEASE;
      r.block_number = BLOCK_NUMBER_W'($urandom);
      r.slot         = s;
      send(r);
   endtask

   function automatic int held_slot();
      int cand[$];
      for (int s = 0; s < NUM_SLOTS; s++)
         if (hold_cnt[s] != 0)
            cand.push_back(s);
      if (cand.size() == 0)
         return -1;
      return cand[$urandom_range(cand.size() - 1)];
   endfunction

   task automatic drain_holds();
      int s;
      s = held_slot();
      while (s >= 0) begin
         give_back(SLOT_W'(s));
         s = held_slot();
      end
   endtask

   initial begin : stimulus
      logic [BLOCK_BITS-1:0] pool [64];
      logic [BLOCK_BITS-1:0] blk;
      logic [BLOCK_BITS-1:0] first_blk;
      int                    pool_n;
      int                    acq_pct;
      int                    run_len;
      int                    done;
      int                    s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed
      idle_pct = 0;
      acquire('0);                    // all tags zero: hits invalid most recent slot
      acquire('0);
      acquire('1);                    // miss, least recent slot
      give_back(SLOT_W'(NUM_SLOTS - 1));
      give_back(SLOT_W'(NUM_SLOTS - 1));
      give_back(SLOT_W'(NUM_SLOTS - 1));  // already free
      give_back('0);
      acquire('1);                    // hit on valid free slot
      give_back('1);
      acquire(20'h00001);
      acquire(20'h80000);
      acquire(20'h55555);
      acquire(20'hAAAAA);
      give_back(5'h15);
      give_back(5'h0A);
      drain_holds();

      // hold every slot, then one more miss finds no free buffer
      idle_pct  = 4;
      first_blk = {5'(0), 1'b1, 14'($urandom)};
      acquire(first_blk);
      for (int i = 1; i < NUM_SLOTS; i++)
         acquire({5'(i), 1'b1, 14'($urandom)});
      acquire({5'($urandom), 1'b0, 14'($urandom)} | 20'h1);
      acquire(first_blk);
      drain_holds();

      // saturate one count
      idle_pct = 0;
      blk      = BLOCK_BITS'($urandom);
      repeat (int'(REF_MAX) + 2) acquire(blk);
      drain_holds();
      give_back(SLOT_W'($urandom));

      // random episodes
      done = 0;
      while (done < RANDOM_ITEMS) begin
         pool_n = $urandom_range(2, 48);
         for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(7))
               0: begin
                  pool[i] = '0;
               end
               1: begin
                  pool[i] = '1;
               end
               2: begin
                  pool[i] = BLOCK_BITS'($urandom_range(15));
               end
               default: begin
                  pool[i] = BLOCK_BITS'($urandom);
               end
            endcase
         end
         acq_pct = $urandom_range(35, 80);
         run_len = $urandom_range(20, 80);
         case ($urandom_range(3))
            0: idle_pct = 0;
            1: idle_pct = 3;
            2: idle_pct = 10;
            default: idle_pct = 30;
         endcase
         for (int k = 0; k < run_len && done < RANDOM_ITEMS; k++) begin
            if (done >= RANDOM_ITEMS - CALM_TAIL)
               idle_pct = 0;
            if ($urandom_range(9) == 0) begin
               send($bits(req_type)'($urandom));
            end else if ($urandom_range(99) < acq_pct) begin
               acquire(pool[$urandom_range(pool_n - 1)]);
            end else begin
               s = held_slot();
               give_back(s >= 0 ? SLOT_W'(s) : SLOT_W'($urandom));
            end
            done++;
         end
      end

      wait (n_checked == n_accepted);
      repeat (BUSY_CYCLES + 8) @(posedge clock);
      $display("tb: %0d acquires (%0d hits, %0d fills) and %0d releases checked",
               n_acquire, n_hits, n_fills, n_release);
      $display("tb: status ok %0d, no buffer %0d, unheld %0d, count full %0d",
               status_seen[STATUS_OK], status_seen[STATUS_NO_BUFFER],
               status_seen[STATUS_UNHELD], status_seen[STATUS_COUNT_FULL]);
      if (n_errors == 0 && pending_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/lbc_pkg.sv
src/lbc_cell.sv
src/lbc_ctrl.sv
src/lru_block_buffer_cache.sv
src/lbc_checker.sv
sim/tb_lru_block_buffer_cache.sv
